FILE: design/pfs_pkg.sv
// Shared types, constants and the sRGB threshold table of the packed-float pixel converter.
// Used by the channel interfaces, the lane, the placement unit and the top level.
// No dependencies.
`default_nettype none

package pfs_pkg;

   localparam int PixelWidth   = 32;
   localparam int CodeWidth    = 11;
   localparam int ByteWidth    = 8;
   localparam int OffsetWidth  = 26;
   localparam int DimWidth     = 13;
   localparam int CountWidth   = 12;
   localparam int LinWidth     = 20;
   localparam int ThrWidth     = LinWidth + 1;

   // One decode stage followed by one stage per bit of the threshold search.
   localparam int SearchSteps  = ByteWidth;
   localparam int LaneStages   = SearchSteps + 1;

   localparam logic [DimWidth-1:0] MaxWidth  = 13'd4096;
   localparam logic [DimWidth-1:0] MaxHeight = 13'd4096;

   // Below this fixed-point value (x * 2^20) the curve is the linear segment.
   localparam logic [LinWidth-1:0] LinLimit  = 20'd3283;
   // 12.92 * 255 * 10, applied as (LinScale * x) >> 20 and then divided by ten.
   localparam logic [15:0]         LinScale  = 16'd32946;
   // Divide by ten for values below about one thousand: (v * 205) >> 11.
   localparam logic [7:0]          TenRecip  = 8'd205;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [LaneStages-1:0] stage_en_type;

   typedef struct packed {
      logic [DimWidth-1:0] width;
      logic [DimWidth-1:0] height;
   } frame_type;

   typedef struct packed {
      logic [OffsetWidth-1:0] offset;
      logic                   frame_end;
   } place_type;

   typedef logic [ThrWidth-1:0] thr_table_type [256];

   // Entry b is the smallest x * 2^20 whose encoded byte is at least b on the power
   // segment, i.e. the least X with X^5 * 269025^12 >= (1000 b + 14025)^12 * 2^100.
   // Worked out exactly with wide integers at elaboration.
   function automatic thr_table_type build_thr();
      thr_table_type t;
      logic [383:0]  k12;
      logic [383:0]  rhs;
      logic [383:0]  lhs;
      logic [383:0]  base;
      logic [21:0]   lo;
      logic [21:0]   hi;
      logic [21:0]   mid;
      int            b;
      int            i;
      int            it;
      k12 = 384'd1;
      for (i = 0; i < 12; i++) begin
         k12 = k12 * 384'd269025;
      end
      t[0] = '0;
      for (b = 1; b < 256; b++) begin
         base = 384'(1000 * b + 14025);
         rhs  = 384'd1;
         for (i = 0; i < 12; i++) begin
            rhs = rhs * base;
         end
         rhs = rhs << 100;
         lo  = 22'd0;
         hi  = 22'h100000;
         for (it = 0; it < 21; it++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               lhs = 384'(mid);
               for (i = 0; i < 4; i++) begin
                  lhs = lhs * 384'(mid);
               end
               lhs = lhs * k12;
               if (lhs >= rhs) begin
                  hi = mid;
               end else begin
                  lo = mid + 22'd1;
               end
            end
         end
         t[b] = lo[ThrWidth-1:0];
      end
      return t;
   endfunction

   localparam thr_table_type ThrTable = build_thr();

endpackage

`default_nettype wire

FILE: design/pfs_if.sv
// Valid/ready channel interfaces for the pixel requests and the encoded results.
// Depends on pfs_pkg for the field widths.
`default_nettype none

interface pfs_req_if;
   import pfs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PixelWidth-1:0] packed_pixel;

   modport source (output valid, output packed_pixel, input ready);
   modport sink   (input valid, input packed_pixel, output ready);
endinterface

interface pfs_rsp_if;
   import pfs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ByteWidth-1:0]   blue_byte;
   logic [ByteWidth-1:0]   green_byte;
   logic [ByteWidth-1:0]   red_byte;
   logic [OffsetWidth-1:0] byte_offset;
   logic                   frame_end;

   modport source (output valid, output blue_byte, output green_byte, output red_byte,
                   output byte_offset, output frame_end, input ready);
   modport sink   (input valid, input blue_byte, input green_byte, input red_byte,
                   input byte_offset, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: design/pfs_lane.sv
// One color lane: decodes an 11-bit unsigned float and encodes it to an sRGB byte.
// A decode stage is followed by an eight-stage binary search over pfs_pkg::ThrTable.
`default_nettype none

module pfs_lane (
   input  logic                           clock,
   input  pfs_pkg::stage_en_type          adv_i,
   input  logic [pfs_pkg::CodeWidth-1:0]  code_i,
   output logic [pfs_pkg::ByteWidth-1:0]  byte_o
);
   import pfs_pkg::*;

   typedef enum logic [1:0] {
      CLS_NAN  = 2'd0,
      CLS_FULL = 2'd1,
      CLS_LIN  = 2'd2,
      CLS_POW  = 2'd3
   } class_type;

   logic [4:0]          exp_w;
   logic [5:0]          man_w;
   logic [20:0]         x_norm;
   logic [LinWidth-1:0] x_in;
   class_type           cls_in;

   class_type           cls_ff [0:SearchSteps];
   logic [LinWidth-1:0] x_ff   [0:SearchSteps-1];
   logic [ByteWidth-1:0] lo_ff [1:SearchSteps];
   logic [ByteWidth-1:0] lin_ff [1:SearchSteps];

   // Decode: value = x_in / 2^20 exactly for every finite code below one.
   always_comb begin
      exp_w  = code_i[10:6];
      man_w  = code_i[5:0];
      x_norm = {14'd0, 1'b1, man_w} << (exp_w - 5'd1);
      x_in   = (exp_w == 5'd0) ? {14'd0, man_w} : x_norm[LinWidth-1:0];
      if (exp_w == 5'd31) begin
         cls_in = (man_w != 6'd0) ? CLS_NAN : CLS_FULL;
      end else if (exp_w >= 5'd15) begin
         cls_in = CLS_FULL;
      end else if (x_in < LinLimit) begin
         cls_in = CLS_LIN;
      end else begin
         cls_in = CLS_POW;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_i[0]) begin
         cls_ff[0] <= cls_in;
         x_ff[0]   <= x_in;
      end
   end

   for (genvar k = 1; k <= SearchSteps; k++) begin : g_step
      localparam logic [ByteWidth-1:0] StepBit = ByteWidth'(1 << (SearchSteps - k));

      logic [ByteWidth-1:0] lo_prev;
      logic [ByteWidth-1:0] cand;
      logic [ByteWidth-1:0] lo_in;
      logic [ByteWidth-1:0] lin_in;

      if (k == 1) begin : g_first
         logic [27:0] lin_mul;
         assign lo_prev = '0;
         assign lin_mul = 28'(x_ff[0][11:0]) * 28'(LinScale);
         assign lin_in  = lin_mul[27:20];
      end else if (k == 2) begin : g_div
         logic [15:0] div_mul;
         assign lo_prev = lo_ff[k-1];
         assign div_mul = 16'(lin_ff[k-1]) * 16'(TenRecip);
         assign lin_in  = ByteWidth'(div_mul[15:11]);
      end else begin : g_carry
         assign lo_prev = lo_ff[k-1];
         assign lin_in  = lin_ff[k-1];
      end

      assign cand  = lo_prev | StepBit;
      assign lo_in = ({1'b0, x_ff[k-1]} >= ThrTable[cand]) ? cand : lo_prev;

      always_ff @(posedge clock) begin
         if (adv_i[k]) begin
            cls_ff[k] <= cls_ff[k-1];
            lo_ff[k]  <= lo_in;
            lin_ff[k] <= lin_in;
         end
      end

      if (k < SearchSteps) begin : g_x
         always_ff @(posedge clock) begin
            if (adv_i[k]) begin
               x_ff[k] <= x_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      case (cls_ff[SearchSteps])
         CLS_NAN:  byte_o = '0;
         CLS_FULL: byte_o = '1;
         CLS_LIN:  byte_o = lin_ff[SearchSteps];
         default:  byte_o = lo_ff[SearchSteps];
      endcase
   end

endmodule

`default_nettype wire

FILE: design/pfs_place.sv
// Pixel placement: column and row counters, bottom-up byte offset and end-of-frame flag.
// Runs in step with the lanes on the same stage enables; depends on pfs_pkg.
`default_nettype none

module pfs_place (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire_i,
   input  pfs_pkg::stage_en_type adv_i,
   input  pfs_pkg::frame_type    frame_i,
   output pfs_pkg::place_type    place_o
);
   import pfs_pkg::*;

   logic [CountWidth-1:0]  col_ff;
   logic [CountWidth-1:0]  row_ff;
   logic [CountWidth-1:0]  col_cur;
   logic [CountWidth-1:0]  row_cur;
   logic [DimWidth-1:0]    col_next;
   logic [DimWidth-1:0]    row_next;
   logic [DimWidth-1:0]    flip_full;
   logic                   last_in;

   logic [CountWidth-1:0]  flip0_ff;
   logic [DimWidth-1:0]    wid0_ff;
   logic [CountWidth-1:0]  col0_ff;
   logic                   last0_ff;
   logic [24:0]            prod_full;
   logic [23:0]            prod1_ff;
   logic [CountWidth-1:0]  col1_ff;
   logic                   last1_ff;
   logic [23:0]            idx2_ff;
   logic                   last2_ff;
   place_type              pl_ff [3:LaneStages-1];

   // A counter left outside the frame by a size change restarts at zero.
   always_comb begin
      col_cur   = ({1'b0, col_ff} >= frame_i.width)  ? '0 : col_ff;
      row_cur   = ({1'b0, row_ff} >= frame_i.height) ? '0 : row_ff;
      col_next  = {1'b0, col_cur} + 13'd1;
      row_next  = {1'b0, row_cur} + 13'd1;
      flip_full = frame_i.height - 13'd1 - {1'b0, row_cur};
      last_in   = (col_next == frame_i.width) && (row_next == frame_i.height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (fire_i) begin
         if (col_next >= frame_i.width) begin
            col_ff <= '0;
            row_ff <= (row_next >= frame_i.height) ? '0 : row_next[CountWidth-1:0];
         end else begin
            col_ff <= col_next[CountWidth-1:0];
            row_ff <= row_cur;
         end
      end
   end

   assign prod_full = 25'(flip0_ff) * 25'(wid0_ff);

   always_ff @(posedge clock) begin
      if (adv_i[0]) begin
         flip0_ff <= flip_full[CountWidth-1:0];
         wid0_ff  <= frame_i.width;
         col0_ff  <= col_cur;
         last0_ff <= last_in;
      end
      if (adv_i[1]) begin
         prod1_ff <= prod_full[23:0];
         col1_ff  <= col0_ff;
         last1_ff <= last0_ff;
      end
      if (adv_i[2]) begin
         idx2_ff  <= prod1_ff + 24'(col1_ff);
         last2_ff <= last1_ff;
      end
      if (adv_i[3]) begin
         pl_ff[3].offset    <= OffsetWidth'({idx2_ff, 1'b0}) + OffsetWidth'(idx2_ff);
         pl_ff[3].frame_end <= last2_ff;
      end
   end

   for (genvar k = 4; k < LaneStages; k++) begin : g_delay
      always_ff @(posedge clock) begin
         if (adv_i[k]) begin
            pl_ff[k] <= pl_ff[k-1];
         end
      end
   end

   assign place_o = pl_ff[LaneStages-1];

endmodule

`default_nettype wire

FILE: design/packed_float_pixel_to_srgb8.sv
// Top level of the packed-float pixel to sRGB byte converter.
// Uses pfs_pkg, the pfs_req_if/pfs_rsp_if channels, three pfs_lane cores and pfs_place.
//
//   Channel    Direction  Handshake              Carries
//   req_chan   in         valid/ready            packed_pixel (R11 G11 B10 floats)
//   rsp_chan   out        valid/ready            blue/green/red bytes, offset, frame_end
//   csr_*      in         csr_wr_en, no wait     frame_width (0), frame_height (1)
//
// One request is taken every cycle unless a stalled output has filled every stage. Each
// result passes through the decode stage, the eight-step threshold search in each lane
// and the output register. Every stage has its own valid bit and ready runs backward
// through them, so a stalled output only holds back requests once all ten stages are full.
// Reset is synchronous: it empties the pipeline, clears the counters and sets both
// frame dimensions to one.
`default_nettype none

module packed_float_pixel_to_srgb8 (
   input  logic                         clock,
   input  logic                         reset,
   pfs_req_if.sink                      req_chan,
   pfs_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  pfs_pkg::csr_index_type       csr_index,
   input  logic [pfs_pkg::DimWidth-1:0] csr_wdata
);
   import pfs_pkg::*;

   // Configuration registers hold the raw written value; clamping happens below.
   logic [DimWidth-1:0] width_ff;
   logic [DimWidth-1:0] height_ff;
   frame_type           frame_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
         endcase
      end
   end

   // A zero dimension acts as one and an oversize one is held at the maximum.
   always_comb begin
      frame_eff.width  = (width_ff == '0) ? 13'd1 :
                         ((width_ff > MaxWidth) ? MaxWidth : width_ff);
      frame_eff.height = (height_ff == '0) ? 13'd1 :
                         ((height_ff > MaxHeight) ? MaxHeight : height_ff);
   end

   // Stage valid bits. Stages 0 to LaneStages-1 live in the lanes and the placement
   // unit; stage LaneStages is the output register below. A stage can load when it is
   // empty or when the stage after it is loading too.
   logic [LaneStages:0] vld_ff;
   logic [LaneStages:0] vld_in;
   logic [LaneStages:0] rdy;
   logic                fire;

   always_comb begin
      rdy[LaneStages] = !vld_ff[LaneStages] || rsp_chan.ready;
      for (int k = LaneStages - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_chan.valid : vld_ff[0];
      for (int k = 1; k <= LaneStages; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = rdy[0];
   assign fire           = req_chan.valid && rdy[0];

   // The three channels go to three identical lanes. Blue has one mantissa bit fewer,
   // so it is widened to the 11-bit layout with a zero in the low mantissa bit.
   logic [CodeWidth-1:0] red_code;
   logic [CodeWidth-1:0] green_code;
   logic [CodeWidth-1:0] blue_code;
   logic [ByteWidth-1:0] red_lane;
   logic [ByteWidth-1:0] green_lane;
   logic [ByteWidth-1:0] blue_lane;
   place_type            place_lane;

   assign red_code   = req_chan.packed_pixel[10:0];
   assign green_code = req_chan.packed_pixel[21:11];
   assign blue_code  = {req_chan.packed_pixel[31:22], 1'b0};

   pfs_lane u_lane_red (
      .clock  (clock),
      .adv_i  (rdy[LaneStages-1:0]),
      .code_i (red_code),
      .byte_o (red_lane)
   );

   pfs_lane u_lane_green (
      .clock  (clock),
      .adv_i  (rdy[LaneStages-1:0]),
      .code_i (green_code),
      .byte_o (green_lane)
   );

   pfs_lane u_lane_blue (
      .clock  (clock),
      .adv_i  (rdy[LaneStages-1:0]),
      .code_i (blue_code),
      .byte_o (blue_lane)
   );

   pfs_place u_place (
      .clock   (clock),
      .reset   (reset),
      .fire_i  (fire),
      .adv_i   (rdy[LaneStages-1:0]),
      .frame_i (frame_eff),
      .place_o (place_lane)
   );

   // Merge stage: the three lane bytes and the placement join in the output register.
   logic [ByteWidth-1:0] blue_ff;
   logic [ByteWidth-1:0] green_ff;
   logic [ByteWidth-1:0] red_ff;
   place_type            place_ff;

   always_ff @(posedge clock) begin
      if (rdy[LaneStages]) begin
         blue_ff  <= blue_lane;
         green_ff <= green_lane;
         red_ff   <= red_lane;
         place_ff <= place_lane;
      end
   end

   assign rsp_chan.valid       = vld_ff[LaneStages];
   assign rsp_chan.blue_byte   = blue_ff;
   assign rsp_chan.green_byte  = green_ff;
   assign rsp_chan.red_byte    = red_ff;
   assign rsp_chan.byte_offset = place_ff.offset;
   assign rsp_chan.frame_end   = place_ff.frame_end;

   // With the output register empty, the whole pipeline can move, so the request port is ready.
   a_ready_when_out_empty : assert property (
      @(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready
   ) else $error("request refused while the output register is empty");

   // A request taken outside reset occupies the first stage in the cycle after.
   a_fire_fills_stage0 : assert property (
      @(posedge clock) disable iff (reset)
      $past(fire && !reset) |-> vld_ff[0]
   ) else $error("accepted request was lost at the first stage");

endmodule

`default_nettype wire

FILE: sim/srgb_pixel_checker.sv
// Checker for the packed-float pixel converter: watches the request, result and CSR ports,
// predicts every result and compares it field by field with what the block returns.
// Depends on pfs_pkg and the pfs_req_if/pfs_rsp_if channel interfaces.
module srgb_pixel_checker (
   input  logic                 clock,
   input  logic                 reset,
   pfs_req_if                   req_chan,
   pfs_rsp_if                   rsp_chan,
   input  logic                 csr_wr_en,
   input  pfs_pkg::csr_index_type csr_index,
   input  logic [pfs_pkg::DimWidth-1:0] csr_wdata,
   output int                   fail_count,
   output int                   pixels_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import pfs_pkg::*;

   typedef struct {
      logic [ByteWidth-1:0]   blue_byte;
      logic [ByteWidth-1:0]   green_byte;
      logic [ByteWidth-1:0]   red_byte;
      logic [OffsetWidth-1:0] byte_offset;
      logic                   frame_end;
   } srgb_pixel_type;

   logic [ByteWidth-1:0] srgb_of_code [2048];
   logic [DimWidth-1:0]  frame_cols;
   logic [DimWidth-1:0]  frame_rows;
   int unsigned          col_pos;
   int unsigned          row_pos;
   srgb_pixel_type       expected_pixels [$];
   srgb_pixel_type       want_px;
   int                   mismatches;

   // Exact sRGB byte of one 11-bit float code. The power segment is decided by comparing
   // x^5 * 269025^12 with (1000 b + 14025)^12 in wide integers, x = mant / 2^shift.
   function automatic logic [ByteWidth-1:0] srgb_byte(logic [CodeWidth-1:0] code);
      logic [4:0]   expo;
      logic [5:0]   frac;
      int unsigned  mant;
      int unsigned  shift;
      logic [63:0]  lin_lhs;
      logic [63:0]  lin_rhs;
      logic [383:0] lhs;
      logic [383:0] rhs;
      int           lo;
      int           hi;
      int           mid;
      int           k;
      expo = code[10:6];
      frac = code[5:0];
      if (expo == 5'd31) return (frac != 6'd0) ? 8'd0 : 8'd255;
      if (expo >= 5'd15) return 8'd255;
      mant  = (expo != 5'd0) ? 64 + frac : frac;
      shift = (expo != 5'd0) ? 21 - expo : 20;
      lin_lhs = 64'(mant) * 64'd10000000;
      lin_rhs = 64'd31308 << shift;
      if (lin_lhs < lin_rhs) return 8'(((64'd32946 * 64'(mant)) >> shift) / 64'd10);
      lhs = 384'd1;
      for (k = 0; k < 5; k++) lhs = lhs * 384'(mant);
      for (k = 0; k < 12; k++) lhs = lhs * 384'd269025;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         rhs = 384'd1;
         for (k = 0; k < 12; k++) rhs = rhs * 384'(1000 * mid + 14025);
         rhs = rhs << (5 * shift);
         if (lhs >= rhs) lo = mid;
         else hi = mid - 1;
      end
      return 8'(lo);
   endfunction

   // Converts one pixel and places it in the bottom-up destination image, advancing
   // the column and row position.
   function automatic srgb_pixel_type convert_pixel(logic [PixelWidth-1:0] px);
      srgb_pixel_type   res;
      int unsigned      w;
      int unsigned      h;
      logic [9:0]       blue10;
      longint unsigned  offs;
      w = (frame_cols == '0) ? 1 : (frame_cols > MaxWidth) ? MaxWidth : frame_cols;
      h = (frame_rows == '0) ? 1 : (frame_rows > MaxHeight) ? MaxHeight : frame_rows;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      blue10         = px[31:22];
      res.blue_byte  = srgb_of_code[{blue10[9:5], blue10[4:0], 1'b0}];
      res.green_byte = srgb_of_code[px[21:11]];
      res.red_byte   = srgb_of_code[px[10:0]];
      offs = 3 * (longint'(h - 1 - row_pos) * w + col_pos);
      res.byte_offset = offs[OffsetWidth-1:0];
      res.frame_end   = (col_pos == w - 1) && (row_pos == h - 1);
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      return res;
   endfunction

   // Reports one field that differs and returns how many mismatches it found.
   function automatic int check_field(string name, longint unsigned want,
                                      longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   initial begin
      for (int c = 0; c < 2048; c++) srgb_of_code[c] = srgb_byte(CodeWidth'(c));
   end

   always @(posedge clock) begin
      if (reset) begin
         frame_cols = 13'd1;
         frame_rows = 13'd1;
         col_pos    = 0;
         row_pos    = 0;
         expected_pixels.delete();
         fail_count     <= 0;
         pixels_checked <= 0;
      end else begin
         mismatches = 0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result with offset %0d arrived with no request outstanding",
                      rsp_chan.byte_offset);
               mismatches += 1;
            end else begin
               want_px = expected_pixels.pop_front();
               mismatches += check_field("blue_byte", want_px.blue_byte,
                                         rsp_chan.blue_byte);
               mismatches += check_field("green_byte", want_px.green_byte,
                                         rsp_chan.green_byte);
               mismatches += check_field("red_byte", want_px.red_byte,
                                         rsp_chan.red_byte);
               mismatches += check_field("byte_offset", want_px.byte_offset,
                                         rsp_chan.byte_offset);
               mismatches += check_field("frame_end", want_px.frame_end,
                                         rsp_chan.frame_end);
               pixels_checked <= pixels_checked + 1;
            end
         end
         fail_count <= fail_count + mismatches;
         if (req_chan.valid && req_chan.ready)
            expected_pixels.push_back(convert_pixel(req_chan.packed_pixel));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_cols = csr_wdata;
               CSR_FRAME_HEIGHT: frame_rows = csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

FILE: sim/tb.sv
// Top of the converter testbench: clock, reset, request stimulus, result back-pressure,
// frame size programming and the final verdict.
// Depends on pfs_pkg, the channel interfaces, the converter and srgb_pixel_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pfs_pkg::*;

   // The slack after the last result covers the result latency and a little more, so that
   // a stray extra result still shows up.
   localparam int ResultLatency = 10;
   localparam int DrainSlack    = ResultLatency + 4;
   // About 450 requests with both sides idling as long as idle_cycles allows, plus the
   // drains between phases, stay well under this.
   localparam int CycleLimit    = 400000;
   localparam int RandomPixels  = 430;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   csr_index_type       csr_index;
   logic [DimWidth-1:0] csr_wdata;

   // When calm is set, neither side idles, so some phases run at full rate.
   bit calm;
   int pixels_sent;
   int pixels_checked;
   int fail_count;
   int cycle_count;
   int stall_left;
   int rsp_wait;

   pfs_req_if req_chan ();
   pfs_rsp_if rsp_chan ();

   packed_float_pixel_to_srgb8 dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   srgb_pixel_checker pixel_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pixels_checked (pixels_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle cycles in front of one request or after one result. At least a third of the draws
   // are zero so that back-to-back traffic is common even outside calm phases.
   function automatic int idle_cycles();
      if (calm) return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
   endfunction

   // The result side holds ready low for a freshly drawn number of cycles after
   // every result it takes.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (rsp_chan.ready && rsp_chan.valid) begin
         rsp_wait = idle_cycles();
         stall_left     <= rsp_wait;
         rsp_chan.ready <= (rsp_wait == 0);
      end else if (!rsp_chan.ready) begin
         if (stall_left <= 1) rsp_chan.ready <= 1'b1;
         stall_left <= stall_left - 1;
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [PixelWidth-1:0] pack_pixel(logic [10:0] red, logic [10:0] green,
                                                        logic [9:0] blue);
      return {blue, green, red};
   endfunction

   // One random 11-bit float code. Most draws land below 1.0, where the curve does its
   // work; the rest are fully random, special encodings or near the linear/power knee.
   function automatic logic [10:0] random_code();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return {5'($urandom_range(0, 14)), 6'($urandom)};
         4, 5:       return 11'($urandom);
         6: begin
            case ($urandom_range(0, 3))
               0:       return 11'h000;
               1:       return 11'h7C0;
               2:       return {5'd31, 6'($urandom_range(1, 63))};
               default: return 11'h3C0;
            endcase
         end
         default:    return {5'($urandom_range(5, 7)), 6'($urandom)};
      endcase
   endfunction

   function automatic logic [PixelWidth-1:0] random_pixel();
      logic [10:0] blue_code;
      blue_code = random_code();
      return pack_pixel(random_code(), random_code(), {blue_code[10:6], blue_code[5:1]});
   endfunction

   // Offers one request after an idle gap and returns once it is taken. Valid stays
   // high when the next request follows with no gap.
   task automatic send_pixel(logic [PixelWidth-1:0] px);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.packed_pixel <= px;
      do @(posedge clock); while (!req_chan.ready);
      pixels_sent++;
   endtask

   // Lowers valid and waits until every request sent so far has its result back, then
   // lets the pipeline settle before anything else happens.
   task automatic wait_results();
      req_chan.valid <= 1'b0;
      while (pixels_checked != pixels_sent) @(posedge clock);
      repeat (DrainSlack) @(posedge clock);
   endtask

   // Writes the frame width register, then the frame height register. Only called while the
   // block is idle.
   task automatic set_frame(logic [DimWidth-1:0] cols, logic [DimWidth-1:0] rows);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int                  remaining;
      int                  burst;
      logic [DimWidth-1:0] cols;
      logic [DimWidth-1:0] rows;

      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.packed_pixel <= '0;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_FRAME_WIDTH;
      csr_wdata             <= '0;
      calm                   = 1'b0;
      pixels_sent            = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed encodings in the reset frame of one pixel, so every result carries
      // offset zero and the frame end flag.
      send_pixel(pack_pixel(11'h000, 11'h000, 10'h000));
      send_pixel(32'hFFFF_FFFF);
      // Infinity on every channel, then NaN with the smallest and largest mantissa.
      send_pixel(pack_pixel(11'h7C0, 11'h7C0, 10'h3E0));
      send_pixel(pack_pixel(11'h7C1, 11'h7FF, 10'h3E1));
      // Exactly one, then codes just below one, the largest for red and blue.
      send_pixel(pack_pixel(11'h3C0, 11'h3C0, 10'h1E0));
      send_pixel(pack_pixel(11'h3BF, 11'h3BE, 10'h1DF));
      // Denormals (the smallest and the largest), the smallest normal and the largest finite code.
      send_pixel(pack_pixel(11'h001, 11'h03F, 10'h001));
      send_pixel(pack_pixel(11'h040, 11'h7BF, 10'h01F));
      // Codes on both sides of the linear-to-power turn, plus the values two and about one half.
      send_pixel(pack_pixel(11'd422, 11'd423, {5'd6, 5'd19}));
      send_pixel(pack_pixel(11'h400, 11'h37F, {5'd6, 5'd20}));
      wait_results();

      // A zero width and height act as a single pixel.
      set_frame('0, '0);
      send_pixel(random_pixel());
      send_pixel(random_pixel());
      wait_results();

      // Stop in the middle of a 4x3 frame at column 1, row 1, then shrink the width to
      // one: the column restarts while the row carries on, and the next pixel ends
      // the new 1x2 frame.
      set_frame(13'd4, 13'd3);
      repeat (5) send_pixel(random_pixel());
      wait_results();
      set_frame(13'd1, 13'd2);
      send_pixel(random_pixel());
      send_pixel(random_pixel());
      wait_results();

      // Register values above the maximum act as the maximum; the first rows of the
      // largest frame carry the highest offsets.
      set_frame(13'h1FFF, 13'h1FFF);
      repeat (3) send_pixel(random_pixel());
      wait_results();
      set_frame(MaxWidth, MaxHeight);
      repeat (2) send_pixel(random_pixel());
      wait_results();

      // Random phases, each with its own frame size. Bursts need not be whole frames,
      // so most phases start with the position left over from the one before.
      remaining = RandomPixels;
      while (remaining > 0) begin
         case ($urandom_range(0, 9))
            0: begin
               cols = '0;
               rows = DimWidth'($urandom_range(1, 6));
            end
            1: begin
               cols = DimWidth'($urandom_range(4097, 8191));
               rows = DimWidth'($urandom_range(0, 3));
            end
            2: begin
               cols = 13'd1;
               rows = DimWidth'($urandom_range(1, 8));
            end
            3: begin
               cols = DimWidth'($urandom_range(1, 12));
               rows = DimWidth'($urandom);
            end
            default: begin
               cols = DimWidth'($urandom_range(1, 12));
               rows = DimWidth'($urandom_range(1, 6));
            end
         endcase
         calm  = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(20, 60);
         if (burst > remaining) burst = remaining;
         set_frame(cols, rows);
         repeat (burst) send_pixel(random_pixel());
         wait_results();
         remaining -= burst;
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
